@@ rtl/dsx_pkg.sv @@
// dsx_pkg: shared constants, types and codes for the dominating set extension search
// used by dsx_step_unit and dominating_set_extension_search_unit
package dsx_pkg;

  localparam int MaxNodes = 16;
  localparam int NodeW    = MaxNodes;
  localparam int IdxW     = $clog2(MaxNodes);
  localparam int CntW     = $clog2(MaxNodes + 1);
  localparam int WordW    = MaxNodes + 1;
  localparam int CfgDataW = 5;
  localparam int CfgIdxW  = 2;

  localparam logic [1:0] CmdSetEdge = 2'd0;
  localparam logic [1:0] CmdClrEdge = 2'd1;
  localparam logic [1:0] CmdQuery   = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgBoundary = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInternal = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCapMode  = 2'd2;

  typedef logic [NodeW-1:0] row_t;
  typedef row_t [MaxNodes-1:0] adj_t;

  typedef struct packed {
    logic             covered;
    logic [WordW-1:0] next_word;
  } step_res_t;

endpackage

@@ rtl/dsx_step_unit.sv @@
// dsx_step_unit: one domination test and the next same-size subset word per cycle
// depends on dsx_pkg
module dsx_step_unit (
  input  dsx_pkg::adj_t             rows_i,
  input  dsx_pkg::row_t             dom_i,
  input  dsx_pkg::row_t             excused_i,
  input  dsx_pkg::row_t             full_i,
  input  logic [dsx_pkg::WordW-1:0] word_i,
  output dsx_pkg::step_res_t        res_o
);

  dsx_pkg::row_t              hit;
  logic [dsx_pkg::WordW-1:0]  low;
  logic [dsx_pkg::WordW-1:0]  up;
  logic [dsx_pkg::WordW-1:0]  tail;
  logic [$clog2(dsx_pkg::WordW)-1:0] sh;

  always_comb begin
    hit = dom_i | excused_i;
    for (int v = 0; v < dsx_pkg::MaxNodes; v++) begin
      if (dom_i[v]) begin
        hit = hit | rows_i[v];
      end
    end
  end

  // lowest set bit position, then the gosper step with a shift in place of the divide
  always_comb begin
    sh = '0;
    for (int i = dsx_pkg::WordW - 1; i >= 0; i--) begin
      if (word_i[i]) begin
        sh = ($clog2(dsx_pkg::WordW))'(i);
      end
    end
  end

  assign low  = word_i & (~word_i + {{(dsx_pkg::WordW-1){1'b0}}, 1'b1});
  assign up   = word_i + low;
  assign tail = (word_i ^ up) >> 2;

  assign res_o.covered   = ((hit & full_i) == full_i);
  assign res_o.next_word = (tail >> sh) | up;

endmodule

@@ rtl/dominating_set_extension_search_unit.sv @@
// dominating_set_extension_search_unit: adjacency store, query sequencer, output register
// depends on dsx_pkg and dsx_step_unit
//
// channel  direction  handshake          payload
// in       sink       in_valid_i/stall_o command, node_a, node_b, chosen_mask, excused_mask
// out      source     out_valid_o/stall_i extra_count, bound_only, size_clipped
// cfg      sink       cfg_valid_i/ready_o cfg_index, cfg_data
//
// edge commands are applied to the adjacency matrix as they are accepted; a query runs
// the k = 0 test, then candidate subsets in turn through the shared step unit (at most
// 2^n of them), then loads the output register once it is free
// reset clears the adjacency matrix, config registers, sequencer state and output valid at once
// the input stalls while a query runs or its result waits for a free output register
module dominating_set_extension_search_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    in_command_i,
  input  logic [dsx_pkg::IdxW-1:0]      in_node_a_i,
  input  logic [dsx_pkg::IdxW-1:0]      in_node_b_i,
  input  logic [dsx_pkg::NodeW-1:0]     in_chosen_mask_i,
  input  logic [dsx_pkg::NodeW-1:0]     in_excused_mask_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dsx_pkg::CntW-1:0]      out_extra_count_o,
  output logic                          out_bound_only_o,
  output logic                          out_size_clipped_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dsx_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dsx_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StTest0 = 3'd1;
  localparam logic [2:0] StCap   = 3'd2;
  localparam logic [2:0] StSrch  = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  localparam int WordW = dsx_pkg::WordW;
  localparam int CntW  = dsx_pkg::CntW;

  logic [2:0] state_q, state_d;

  dsx_pkg::adj_t rows_q, rows_d;
  logic [4:0] boundary_q, internal_q;
  logic       cap_q;

  dsx_pkg::row_t  xs_q, xs_d, ss_q, ss_d, full_q, full_d;
  logic [CntW-1:0] n_q, n_d, k_q, k_d, res_q, res_d;
  logic [WordW-1:0] c_q, c_d, ones_q, ones_d;
  logic clip_q, clip_d, bound_q, bound_d, capm_q, capm_d;

  logic            out_valid_q, out_valid_d;
  logic [CntW-1:0] out_count_q, out_count_d;
  logic            out_bound_q, out_bound_d, out_clip_q, out_clip_d;

  logic             in_acc, out_free;
  logic [5:0]       total;
  dsx_pkg::row_t    full_w;
  logic [WordW-1:0] cap_next;
  dsx_pkg::row_t    dom;
  dsx_pkg::step_res_t step;

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = ~out_valid_q | ~out_stall_i;

  assign total  = {1'b0, boundary_q} + {1'b0, internal_q};
  assign full_w = dsx_pkg::row_t'((WordW'(1) << n_d) - WordW'(1));
  assign cap_next = {c_q[WordW-2:0], 1'b0};

  assign dom = (state_q == StTest0) ? xs_q : (xs_q | c_q[dsx_pkg::NodeW-1:0]);

  dsx_step_unit u_step (
    .rows_i    (rows_q),
    .dom_i     (dom),
    .excused_i (ss_q),
    .full_i    (full_q),
    .word_i    (c_q),
    .res_o     (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boundary_q <= '0;
      internal_q <= '0;
      cap_q      <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        dsx_pkg::CfgBoundary: boundary_q <= cfg_data_i[4:0];
        dsx_pkg::CfgInternal: internal_q <= cfg_data_i[4:0];
        dsx_pkg::CfgCapMode:  cap_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rows_d = rows_q;
    if (in_acc) begin
      case (in_command_i)
        dsx_pkg::CmdSetEdge: begin
          if (in_node_a_i != in_node_b_i) begin
            rows_d[in_node_a_i][in_node_b_i] = 1'b1;
            rows_d[in_node_b_i][in_node_a_i] = 1'b1;
          end
        end
        dsx_pkg::CmdClrEdge: begin
          rows_d[in_node_a_i][in_node_b_i] = 1'b0;
          rows_d[in_node_b_i][in_node_a_i] = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= '0;
    end else begin
      rows_q <= rows_d;
    end
  end

  always_comb begin
    state_d = state_q;
    xs_d    = xs_q;
    ss_d    = ss_q;
    full_d  = full_q;
    n_d     = n_q;
    k_d     = k_q;
    c_d     = c_q;
    ones_d  = ones_q;
    res_d   = res_q;
    clip_d  = clip_q;
    bound_d = bound_q;
    capm_d  = capm_q;
    if (total > 6'(dsx_pkg::MaxNodes)) begin
      n_d = CntW'(dsx_pkg::MaxNodes);
    end else begin
      n_d = total[CntW-1:0];
    end
    if (state_q != StIdle) begin
      n_d = n_q;
    end
    unique case (state_q)
      StIdle: begin
        if (in_acc && in_command_i == dsx_pkg::CmdQuery) begin
          full_d  = full_w;
          xs_d    = in_chosen_mask_i & full_w;
          ss_d    = in_excused_mask_i & full_w;
          clip_d  = (total > 6'(dsx_pkg::MaxNodes));
          capm_d  = cap_q;
          bound_d = 1'b0;
          state_d = StTest0;
        end
      end
      StTest0: begin
        c_d    = WordW'(1);
        ones_d = WordW'(1);
        k_d    = CntW'(1);
        if (step.covered) begin
          res_d   = '0;
          state_d = StDone;
        end else if (capm_q) begin
          state_d = StCap;
        end else begin
          state_d = StSrch;
        end
      end
      StCap: begin
        c_d = cap_next;
        if (step.covered) begin
          res_d   = CntW'(1);
          state_d = StDone;
        end else if (cap_next > {1'b0, full_q}) begin
          res_d   = CntW'(2);
          bound_d = 1'b1;
          state_d = StDone;
        end
      end
      StSrch: begin
        c_d = step.next_word;
        if (step.covered) begin
          res_d   = k_q;
          state_d = StDone;
        end else if (step.next_word > {1'b0, full_q}) begin
          if (k_q == n_q) begin
            res_d   = n_q;
            state_d = StDone;
          end else begin
            ones_d = {ones_q[WordW-2:0], 1'b1};
            c_d    = {ones_q[WordW-2:0], 1'b1};
            k_d    = k_q + CntW'(1);
          end
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    out_count_d = out_count_q;
    out_bound_d = out_bound_q;
    out_clip_d  = out_clip_q;
    if (state_q == StDone && out_free) begin
      out_valid_d = 1'b1;
      out_count_d = res_q;
      out_bound_d = bound_q;
      out_clip_d  = clip_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xs_q        <= xs_d;
    ss_q        <= ss_d;
    full_q      <= full_d;
    n_q         <= n_d;
    k_q         <= k_d;
    c_q         <= c_d;
    ones_q      <= ones_d;
    res_q       <= res_d;
    clip_q      <= clip_d;
    bound_q     <= bound_d;
    capm_q      <= capm_d;
    out_count_q <= out_count_d;
    out_bound_q <= out_bound_d;
    out_clip_q  <= out_clip_d;
  end

  assign out_valid_o        = out_valid_q;
  assign out_extra_count_o  = out_count_q;
  assign out_bound_only_o   = out_bound_q;
  assign out_size_clipped_o = out_clip_q;

  logic sym_ok;
  always_comb begin
    sym_ok = 1'b1;
    for (int i = 0; i < dsx_pkg::MaxNodes; i++) begin
      if (rows_q[i][i]) begin
        sym_ok = 1'b0;
      end
      for (int j = 0; j < dsx_pkg::MaxNodes; j++) begin
        if (rows_q[i][j] != rows_q[j][i]) begin
          sym_ok = 1'b0;
        end
      end
    end
  end

  a_sym: assert property (@(posedge clk_i) disable iff (!rst_ni) sym_ok)
    else $error("adjacency matrix lost symmetry or holds a self edge");

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_bound_only_o |-> out_extra_count_o == CntW'(2))
    else $error("bound flag without a count of two");

  a_srch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSrch |-> c_q != '0 && k_q <= n_q && !capm_q)
    else $error("subset search out of range");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDone && out_free |=> out_valid_o && state_q == StIdle)
    else $error("finished query not delivered");

endmodule

@@ tb/tb_dominating_set_extension_search_unit.sv @@
// testbench for dominating_set_extension_search_unit: edge and query beats against
// an in-bench domination search predictor, with random idling on the input and output channels
// depends on dsx_pkg and the rtl of dominating_set_extension_search_unit
`timescale 1ns / 1ps

module tb_dominating_set_extension_search_unit;

  localparam int MaxNodes = dsx_pkg::MaxNodes;
  localparam int NodeW    = dsx_pkg::NodeW;
  localparam int IdxW     = dsx_pkg::IdxW;
  localparam int CntW     = dsx_pkg::CntW;
  localparam int CfgIdxW  = dsx_pkg::CfgIdxW;
  localparam int CfgDataW = dsx_pkg::CfgDataW;

  localparam logic [1:0]         CmdUnused  = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgSpare   = 2'd3;
  localparam int unsigned        CycleLimit = 4_000_000;
  localparam int                 NumPhases  = 13;
  localparam int                 PhaseItems = 43;

  typedef struct packed {
    logic [1:0]      command;
    logic [IdxW-1:0] node_a;
    logic [IdxW-1:0] node_b;
    dsx_pkg::row_t   chosen;
    dsx_pkg::row_t   excused;
  } cmd_item_t;

  typedef struct packed {
    logic [CntW-1:0] extra;
    logic            bound;
    logic            clipped;
  } answer_t;

  class extension_tracker;
    dsx_pkg::row_t   adj [MaxNodes];
    logic [4:0]      boundary_cnt;
    logic [4:0]      internal_cnt;
    logic            cap_on;
    answer_t         pending [$];
    int              errors;
    int              edge_beats;
    int              queries;
    int              capped_queries;
    int              clipped_queries;

    function new();
      foreach (adj[i]) adj[i] = '0;
      boundary_cnt = '0;
      internal_cnt = '0;
      cap_on = 1'b0;
    endfunction

    function void configure(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        dsx_pkg::CfgBoundary: boundary_cnt = val;
        dsx_pkg::CfgInternal: internal_cnt = val;
        dsx_pkg::CfgCapMode:  cap_on = val[0];
        default: ;
      endcase
    endfunction

    function int active_nodes();
      int total;
      total = int'(boundary_cnt) + int'(internal_cnt);
      return (total > MaxNodes) ? MaxNodes : total;
    endfunction

    function bit dominates(dsx_pkg::row_t dom, dsx_pkg::row_t exc, dsx_pkg::row_t full);
      dsx_pkg::row_t hit;
      hit = dom | exc;
      for (int v = 0; v < MaxNodes; v++) begin
        if (dom[v]) hit |= adj[v];
      end
      return (hit & full) == full;
    endfunction

    function answer_t min_extension(dsx_pkg::row_t chosen, dsx_pkg::row_t excused);
      answer_t ans;
      int n;
      int best;
      dsx_pkg::row_t full;
      dsx_pkg::row_t xs;
      dsx_pkg::row_t ss;
      n = active_nodes();
      ans = '0;
      ans.clipped = (int'(boundary_cnt) + int'(internal_cnt)) > MaxNodes;
      full = dsx_pkg::row_t'((1 << n) - 1);
      xs = chosen & full;
      ss = excused & full;
      if (dominates(xs, ss, full)) begin
        ans.extra = '0;
      end else if (cap_on) begin
        ans.extra = CntW'(2);
        ans.bound = 1'b1;
        for (int c = 0; c < n; c++) begin
          if (ans.bound && dominates(xs | (dsx_pkg::row_t'(1) << c), ss, full)) begin
            ans.extra = CntW'(1);
            ans.bound = 1'b0;
          end
        end
      end else begin
        best = n;
        for (int m = 1; m < (1 << n); m++) begin
          if ($countones(m) < best && dominates(xs | dsx_pkg::row_t'(m), ss, full)) begin
            best = $countones(m);
          end
        end
        ans.extra = CntW'(best);
      end
      return ans;
    endfunction

    function void note_item(cmd_item_t it);
      case (it.command)
        dsx_pkg::CmdSetEdge: begin
          edge_beats++;
          if (it.node_a != it.node_b) begin
            adj[it.node_a][it.node_b] = 1'b1;
            adj[it.node_b][it.node_a] = 1'b1;
          end
        end
        dsx_pkg::CmdClrEdge: begin
          edge_beats++;
          adj[it.node_a][it.node_b] = 1'b0;
          adj[it.node_b][it.node_a] = 1'b0;
        end
        dsx_pkg::CmdQuery: begin
          queries++;
          if (cap_on) capped_queries++;
          if (int'(boundary_cnt) + int'(internal_cnt) > MaxNodes) clipped_queries++;
          pending.insert(pending.size(), min_extension(it.chosen, it.excused));
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      $display("ERROR %s: got %0d, expected %0d", what, got, want);
    endtask

    task check_answer(answer_t got);
      answer_t want;
      if (pending.size() == 0) begin
        report_mismatch("result beat with no query pending", got.extra, -1);
      end else begin
        want = pending.pop_front();
        if (got.extra !== want.extra) report_mismatch("extra_count", got.extra, want.extra);
        if (got.bound !== want.bound) report_mismatch("bound_only", got.bound, want.bound);
        if (got.clipped !== want.clipped) begin
          report_mismatch("size_clipped", got.clipped, want.clipped);
        end
      end
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            in_command_i = '0;
  logic [IdxW-1:0]       in_node_a_i = '0;
  logic [IdxW-1:0]       in_node_b_i = '0;
  logic [NodeW-1:0]      in_chosen_mask_i = '0;
  logic [NodeW-1:0]      in_excused_mask_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [CntW-1:0]       out_extra_count_o;
  logic                  out_bound_only_o;
  logic                  out_size_clipped_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i = '0;
  logic [CfgDataW-1:0]   cfg_data_i = '0;

  extension_tracker      tracker = new();
  bit                    quiet = 1'b0;
  int unsigned           cycle_count = 0;
  int                    reg_writes = 0;

  dominating_set_extension_search_unit u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_command_i       (in_command_i),
    .in_node_a_i        (in_node_a_i),
    .in_node_b_i        (in_node_b_i),
    .in_chosen_mask_i   (in_chosen_mask_i),
    .in_excused_mask_i  (in_excused_mask_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_extra_count_o  (out_extra_count_o),
    .out_bound_only_o   (out_bound_only_o),
    .out_size_clipped_o (out_size_clipped_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("dominating_set_extension_search_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    answer_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.extra = out_extra_count_o;
        got.bound = out_bound_only_o;
        got.clipped = out_size_clipped_o;
        tracker.check_answer(got);
      end
      out_stall_i <= !quiet && ($urandom_range(99) < 13);
    end
  end

  function automatic cmd_item_t item_of(logic [1:0] cmd, int a, int b, dsx_pkg::row_t x,
                                        dsx_pkg::row_t s);
    cmd_item_t it;
    it.command = cmd;
    it.node_a = IdxW'(a);
    it.node_b = IdxW'(b);
    it.chosen = x;
    it.excused = s;
    return it;
  endfunction

  function automatic cmd_item_t random_item();
    cmd_item_t it;
    int r;
    int n;
    n = tracker.active_nodes();
    r = $urandom_range(99);
    if (r < 45) it.command = dsx_pkg::CmdSetEdge;
    else if (r < 62) it.command = dsx_pkg::CmdClrEdge;
    else if (r < 96) it.command = dsx_pkg::CmdQuery;
    else it.command = CmdUnused;
    // keep most edges inside the active region so queries see them
    if (n >= 2 && $urandom_range(3) != 0) begin
      it.node_a = IdxW'($urandom_range(n - 1));
      it.node_b = IdxW'($urandom_range(n - 1));
    end else begin
      it.node_a = IdxW'($urandom_range(MaxNodes - 1));
      it.node_b = IdxW'($urandom_range(MaxNodes - 1));
    end
    it.chosen = dsx_pkg::row_t'($urandom);
    it.excused = dsx_pkg::row_t'($urandom);
    // full search over many nodes is slow, so few vertices stay uncovered
    if (it.command == dsx_pkg::CmdQuery && !tracker.cap_on && n > 9) begin
      it.excused = dsx_pkg::row_t'($urandom | $urandom | $urandom);
    end else if ($urandom_range(3) == 0) begin
      it.chosen = '0;
      it.excused = dsx_pkg::row_t'($urandom & $urandom);
    end
    return it;
  endfunction

  task automatic push_item(cmd_item_t it);
    in_valid_i <= 1'b1;
    in_command_i <= it.command;
    in_node_a_i <= it.node_a;
    in_node_b_i <= it.node_b;
    in_chosen_mask_i <= it.chosen;
    in_excused_mask_i <= it.excused;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_item(it);
    if (!quiet && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.configure(idx, val);
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic set_region(int boundary, int inner_cnt, bit cap);
    write_reg(dsx_pkg::CfgBoundary, CfgDataW'(boundary));
    write_reg(dsx_pkg::CfgInternal, CfgDataW'(inner_cnt));
    // upper data bits of the mode register are don't-care
    write_reg(dsx_pkg::CfgCapMode, CfgDataW'(($urandom_range(15) << 1) | cap));
  endtask

  // drop valid, drain every pending answer, then let a trailing edge beat retire
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    int nb;
    int ni;
    bit cap;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty region, unused command, self edges
    push_item(item_of(dsx_pkg::CmdQuery, 0, 0, 16'hFFFF, 16'hFFFF));
    push_item(item_of(CmdUnused, 9, 3, 16'h1234, 16'hABCD));
    push_item(item_of(dsx_pkg::CmdSetEdge, 7, 7, 16'h0, 16'h0));
    push_item(item_of(dsx_pkg::CmdClrEdge, 7, 7, 16'hFFFF, 16'hFFFF));
    settle();

    write_reg(dsx_pkg::CfgBoundary, CfgDataW'(16));
    write_reg(CfgSpare, CfgDataW'(31));
    push_item(item_of(dsx_pkg::CmdQuery, 0, 0, 16'h0000, 16'h0000));
    push_item(item_of(dsx_pkg::CmdQuery, 15, 15, 16'h0000, 16'h7FFF));
    push_item(item_of(dsx_pkg::CmdQuery, 0, 0, 16'hFFFF, 16'h0000));
    push_item(item_of(dsx_pkg::CmdSetEdge, 0, 15, 16'h0, 16'h0));
    push_item(item_of(dsx_pkg::CmdSetEdge, 15, 0, 16'h0, 16'h0));
    push_item(item_of(dsx_pkg::CmdQuery, 0, 0, 16'h0001, 16'h7FFE));
    push_item(item_of(dsx_pkg::CmdClrEdge, 15, 0, 16'h0, 16'h0));
    push_item(item_of(dsx_pkg::CmdQuery, 0, 0, 16'h0001, 16'h7FFE));
    settle();

    // clipped node count in capped mode
    write_reg(dsx_pkg::CfgInternal, CfgDataW'(16));
    write_reg(dsx_pkg::CfgCapMode, CfgDataW'(1));
    push_item(item_of(dsx_pkg::CmdQuery, 0, 0, 16'h0000, 16'h0000));
    push_item(item_of(dsx_pkg::CmdQuery, 0, 0, 16'h0000, 16'hFFFE));
    push_item(item_of(dsx_pkg::CmdSetEdge, 0, 1, 16'h0, 16'h0));
    push_item(item_of(dsx_pkg::CmdQuery, 0, 0, 16'h0000, 16'hFFFC));
    settle();

    // mask bits beyond the region
    set_region(3, 2, 1'b0);
    push_item(item_of(dsx_pkg::CmdQuery, 0, 0, 16'hFFE0, 16'hFFE0));
    push_item(item_of(dsx_pkg::CmdQuery, 0, 0, 16'h0004, 16'h0018));
    settle();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin nb = 0; ni = 16; cap = 1'b1; end
        1: begin nb = 16; ni = 0; cap = 1'b0; end
        2: begin nb = 1; ni = 0; cap = 1'b0; end
        3: begin nb = 0; ni = 1; cap = 1'b1; end
        default: begin
          cap = $urandom_range(1);
          if (cap || $urandom_range(3) == 0) begin
            nb = $urandom_range(16);
            ni = $urandom_range(16);
          end else begin
            nb = $urandom_range(5);
            ni = $urandom_range(4);
          end
        end
      endcase
      quiet = (p == 6 || p == 7);
      set_region(nb, ni, cap);
      repeat (PhaseItems) push_item(random_item());
      settle();
    end

    repeat (20) @(posedge clk_i);
    $display("covered %0d edge beats and %0d queries (%0d capped, %0d clipped)",
             tracker.edge_beats, tracker.queries, tracker.capped_queries,
             tracker.clipped_queries);
    $display("over %0d register writes in %0d cycles", reg_writes, cycle_count);
    if (tracker.errors == 0) begin
      $display("dominating_set_extension_search_unit: match");
    end else begin
      $display("dominating_set_extension_search_unit: mismatch");
    end
    $finish;
  end

endmodule
